FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// A held request keeps its payload on the next edge.
`define ASSERT_HOLD(label, ante, sig) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> $stable(sig)) \
		else $error("assertion failed: label");

`endif

FILE: src/mpnf_pkg.sv
`timescale 1ns / 1ps
package mpnf_pkg;

	localparam int ENTRY_W = 17;
	localparam int VAL_W = 16;
	localparam int OCOL_W = 11;
	localparam int ROW_W = 12;
	localparam int NB_N = 8;

	localparam logic [7:0] REG_FRAME_WIDTH = 8'd0;
	localparam logic [7:0] REG_FRAME_HEIGHT = 8'd1;

	// Neighbor order: top row left to right, middle left, middle right, bottom row.
	// Edge neighbors weigh 2, corners weigh 1.
	localparam logic [1:0] NB_WEIGHT [NB_N] = '{2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1};

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic has_a;
		logic has_b;
		logic has_c;
		logic fill;
		entry_t [NB_N-1:0] nb;
		logic [VAL_W-1:0] center;
		logic [OCOL_W-1:0] a_col;
		logic [ROW_W-1:0] a_row;
		logic [OCOL_W-1:0] bc_col;
		logic [VAL_W-1:0] b_val;
		logic [ROW_W-1:0] c_row;
		logic [VAL_W-1:0] c_val;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic {F_IDLE, F_PUSH} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} back_state_t;

endpackage

FILE: src/masked_pixel_neighbor_fill_top.sv
`timescale 1ns / 1ps
// Front end: an accepted pixel reads both line stores, then in the push state writes them
// back and pushes its job into the queue if it gives results. A full queue holds that state,
// and no new pixel is taken until it ends. Back end: a popped job that fills a masked pixel
// with good neighbors runs the bit-serial divider, then sends its results one at a time.
// Reset clears counters, window, queue and output valid; line stores need no clearing.
module masked_pixel_neighbor_fill_top
	import mpnf_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 2048,
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pixel_value
	input  logic        s_tuser,   // pixel_masked
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_col, out_row, out_value, zero pad
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	q_status_t q_status;
	job_t push_job, pop_job;
	logic push, pop;
	logic [OCOL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic [VAL_W-1:0] out_value;

	assign cfg_ready = 1'b1;
	assign m_tdata = {1'b0, out_value, out_row, out_col};

	mpnf_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_value(s_tdata), .in_masked(s_tuser),
		.cfg_valid, .cfg_index, .cfg_data,
		.q_status, .push, .push_job
	);

	mpnf_queue u_queue (
		.clk, .arst_n, .push, .push_job, .pop, .pop_job, .status(q_status)
	);

	mpnf_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk, .arst_n, .q_status, .pop_job, .pop,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_col, .out_row, .out_value, .out_last(m_tlast)
	);

endmodule

FILE: src/mpnf_queue.sv
`timescale 1ns / 1ps
module mpnf_queue
	import mpnf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      pop_job,
	output q_status_t status
);

	job_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign status.full = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !status.full) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !status.full) wr_q <= !wr_q;
			if (pop && !status.empty) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && !status.full) - 2'(pop && !status.empty);
		end
	end

endmodule

FILE: src/mpnf_front.sv
`timescale 1ns / 1ps
module mpnf_front
	import mpnf_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 2048,
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] in_value,
	input  logic        in_masked,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  q_status_t   q_status,
	output logic        push,
	output job_t        push_job
);

	localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
	localparam logic [15:0] VMASK = 16'((32'd1 << PIXEL_BITS) - 1);

	entry_t mem_old [MAX_LINE_WIDTH];
	entry_t mem_new [MAX_LINE_WIDTH];
	entry_t win_q [3][3];
	entry_t win_d [3][3];
	entry_t rd_old_q, rd_new_q, cur_q;
	logic [AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [11:0] fw_q, fh_q;
	front_state_t state_q, state_d;
	logic [31:0] wd_ext;
	logic [AW-1:0] wd_m1, cc;
	logic [ROW_W-1:0] ht_m1, cr;
	logic row_end, last_row, has_a, advance, cfg_hit;

	always_comb begin
		if (fw_q < 12'd3) wd_ext = 32'd3;
		else if ({20'd0, fw_q} > 32'(MAX_LINE_WIDTH)) wd_ext = 32'(MAX_LINE_WIDTH);
		else wd_ext = {20'd0, fw_q};
		wd_m1 = AW'(wd_ext - 32'd1);
		if (fh_q < 12'd3) ht_m1 = 12'd2;
		else if (fh_q == 12'hFFF) ht_m1 = 12'd4094;
		else ht_m1 = fh_q - 12'd1;
	end

	assign row_end = (col_q >= wd_m1);
	assign last_row = (row_q >= ht_m1);
	assign has_a = (row_q != '0) && (col_q != '0);
	assign cc = col_q - AW'(1);
	assign cr = row_q - ROW_W'(1);
	assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (in_valid) state_d = F_PUSH;
			F_PUSH: if (!q_status.full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		advance = (state_q == F_PUSH) && !q_status.full;
		push = advance && (has_a || last_row);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i][0] = win_q[i][1];
			win_d[i][1] = win_q[i][2];
		end
		win_d[0][2] = rd_old_q;
		win_d[1][2] = rd_new_q;
		win_d[2][2] = cur_q;
	end

	always_comb begin
		push_job.has_a = has_a;
		push_job.has_b = has_a && row_end;
		push_job.has_c = last_row;
		push_job.nb = {win_d[2][2], win_d[2][1], win_d[2][0], win_d[1][2],
			win_d[1][0], win_d[0][2], win_d[0][1], win_d[0][0]};
		push_job.center = win_d[1][1][VAL_W-1:0];
		push_job.fill = (cr != '0) && (cc != '0) && (cc < wd_m1) && win_d[1][1][VAL_W];
		push_job.a_col = OCOL_W'({{OCOL_W{1'b0}}, cc});
		push_job.a_row = cr;
		push_job.bc_col = OCOL_W'({{OCOL_W{1'b0}}, col_q});
		push_job.b_val = rd_new_q[VAL_W-1:0];
		push_job.c_row = row_q;
		push_job.c_val = cur_q[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_q <= {in_masked, in_value & VMASK};
			rd_old_q <= mem_old[col_q];
			rd_new_q <= mem_new[col_q];
		end
		if (advance) begin
			mem_old[col_q] <= rd_new_q;
			mem_new[col_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q <= '0;
			row_q <= '0;
			fw_q <= 12'd2048;
			fh_q <= 12'd2048;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (advance) begin
				win_q <= win_d;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
			if (cfg_hit) begin
				if (cfg_index == REG_FRAME_WIDTH) fw_q <= cfg_data;
				else fh_q <= cfg_data;
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

endmodule

FILE: src/mpnf_back.sv
`timescale 1ns / 1ps
module mpnf_back
	import mpnf_pkg::*;
#(
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  q_status_t   q_status,
	input  job_t        pop_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [OCOL_W-1:0] out_col,
	output logic [ROW_W-1:0]  out_row,
	output logic [VAL_W-1:0]  out_value,
	output logic        out_last
);

	// Numerator 2s+w: s needs PIXEL_BITS+4 bits for a total weight of 12.
	localparam int NW = PIXEL_BITS + 6;
	localparam int DW = 5;
	localparam int CW = $clog2(NW + 1);

	back_state_t state_q, state_d;
	job_t job_q;
	logic [2:0] pend_q;
	logic [NW-1:0] num_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [VAL_W-1:0] a_val_q;
	logic [NW-1:0] s_sum;
	logic [3:0] w_sum;
	logic [DW:0] rem_sh, rem_sub;
	logic load_ok, div_done;
	logic [2:0] pick, rest;

	always_comb begin
		s_sum = '0;
		w_sum = '0;
		for (int k = 0; k < NB_N; k++) begin
			if (!pop_job.nb[k][VAL_W]) begin
				s_sum = s_sum + (NW'(pop_job.nb[k][VAL_W-1:0]) << (NB_WEIGHT[k] - 2'd1));
				w_sum = w_sum + 4'(NB_WEIGHT[k]);
			end
		end
	end

	assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign div_done = (cnt_q == CW'(NW - 1));
	assign load_ok = !out_valid || out_ready;

	always_comb begin
		pick = 3'b000;
		priority if (pend_q[0]) pick = 3'b001;
		else if (pend_q[1]) pick = 3'b010;
		else if (pend_q[2]) pick = 3'b100;
		rest = pend_q & ~pick;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_status.empty) state_d = (pop_job.fill && w_sum != '0) ? B_DIV : B_OUT;
			B_DIV: if (div_done) state_d = B_OUT;
			B_OUT: if (load_ok && rest == '0) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE) && !q_status.empty;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (pop) begin
				job_q <= pop_job;
				a_val_q <= pop_job.center;
				num_q <= (s_sum << 1) + NW'(w_sum);
				den_q <= {w_sum, 1'b0};
				rem_q <= '0;
			end
			B_DIV: begin
				num_q <= num_q << 1;
				if (!rem_sub[DW]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				if (div_done) a_val_q <= (!rem_sub[DW]) ? VAL_W'({quo_q[NW-2:0], 1'b1})
					: VAL_W'({quo_q[NW-2:0], 1'b0});
			end
			B_OUT: if (load_ok) begin
				out_last <= (rest == '0);
				unique case (pick)
					3'b001: begin
						out_col <= job_q.a_col; out_row <= job_q.a_row; out_value <= a_val_q;
					end
					3'b010: begin
						out_col <= job_q.bc_col; out_row <= job_q.a_row; out_value <= job_q.b_val;
					end
					default: begin
						out_col <= job_q.bc_col; out_row <= job_q.c_row; out_value <= job_q.c_val;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pend_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				pend_q <= {pop_job.has_c, pop_job.has_b, pop_job.has_a};
				cnt_q <= '0;
			end
			if (state_q == B_DIV) cnt_q <= cnt_q + CW'(1);
			if (state_q == B_OUT && load_ok) begin
				out_valid <= 1'b1;
				pend_q <= rest;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

FILE: src/mpnf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpnf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`ASSERT_HOLD(a_out_hold, m_tvalid && !m_tready, {m_tlast, m_tdata})
	`ASSERT_IMPL(a_row_range, m_tvalid, m_tdata[22:11] != 12'hFFF)
	`ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[39] == 1'b0)
	`ASSERT_IMPL(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind masked_pixel_neighbor_fill_top mpnf_checker u_checker (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_valid, .cfg_ready
);

FILE: tb/masked_pixel_neighbor_fill_top_test.sv
`timescale 1ns / 1ps
module masked_pixel_neighbor_fill_top_test;
	import mpnf_pkg::*;

	typedef struct {
		logic [15:0] value;
		logic        masked;
	} pixel_t;

	typedef struct {
		logic [10:0] col;
		logic [11:0] row;
		logic [15:0] value;
		logic        last;
	} fill_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // pixel_value
	logic        s_tuser;   // pixel_masked
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // out_col, out_row, out_value, zero pad
	logic        m_tlast;   // last_of_run
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [11:0] cfg_data;

	masked_pixel_neighbor_fill_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state.
	logic [16:0] row_above2 [2048];
	logic [16:0] row_above1 [2048];
	logic [16:0] win [3][3];
	int unsigned col_pos, row_pos;
	logic [11:0] width_reg, height_reg;

	pixel_t       pixel_q[$];
	fill_result_t expected_q[$];
	int unsigned  n_queued, n_taken, errors;
	int unsigned  send_idle_pct, recv_stall_pct;
	bit           pixel_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [15:0] weighted_fill();
		int unsigned s, w, m;
		s = 0;
		w = 0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				if (!(dy == 1 && dx == 1) && !win[dy][dx][16]) begin
					m = (dy != 1 && dx != 1) ? 1 : 2;
					s += m * win[dy][dx][15:0];
					w += m;
				end
			end
		end
		if (w == 0) return win[1][1][15:0];
		return 16'((2 * s + w) / (2 * w));
	endfunction

	task automatic predict_pixel(input logic [15:0] value, input logic masked);
		int unsigned  wd, ht, c, r, cc, cr, n;
		logic [16:0]  cur, old_e, new_e;
		logic [15:0]  v;
		bit           row_end, last_row;
		fill_result_t res[3];
		wd = width_reg < 3 ? 3 : (width_reg > 2048 ? 2048 : width_reg);
		ht = height_reg < 3 ? 3 : height_reg;
		c = col_pos;
		r = row_pos;
		cur = {masked, value};
		row_end = c >= wd - 1;
		last_row = r >= ht - 1;
		n = 0;
		old_e = row_above2[c];
		new_e = row_above1[c];
		row_above2[c] = new_e;
		row_above1[c] = cur;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = old_e;
		win[1][2] = new_e;
		win[2][2] = cur;
		if (r >= 1 && c >= 1) begin
			cr = r - 1;
			cc = c - 1;
			v = win[1][1][15:0];
			if (cr >= 1 && cc >= 1 && cc < wd - 1 && win[1][1][16])
				v = weighted_fill();
			res[n] = '{cc[10:0], cr[11:0], v, 1'b0};
			n++;
			if (row_end) begin
				res[n] = '{c[10:0], cr[11:0], new_e[15:0], 1'b0};
				n++;
			end
		end
		if (last_row) begin
			res[n] = '{c[10:0], r[11:0], value, 1'b0};
			n++;
		end
		if (n > 0) res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
		if (row_end) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Pixel driver.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !pixel_taken)) begin
			pixel_taken = 0;
			if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_q[0].value;
				s_tuser <= pixel_q[0].masked;
				void'(pixel_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	// Input side prediction and output side checking.
	always @(posedge clk) begin
		fill_result_t e;
		if (arst_n && s_tvalid && s_tready && !pixel_taken) begin
			pixel_taken = 1;
			n_taken++;
			predict_pixel(s_tdata, s_tuser);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result col %0d row %0d value %0d last %0b", $time,
					m_tdata[10:0], m_tdata[22:11], m_tdata[38:23], m_tlast);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[10:0] !== e.col || m_tdata[22:11] !== e.row
						|| m_tdata[38:23] !== e.value || m_tlast !== e.last) begin
					$display("%0t: expected col %0d row %0d value %0d last %0b, got col %0d row %0d value %0d last %0b",
						$time, e.col, e.row, e.value, e.last, m_tdata[10:0],
						m_tdata[22:11], m_tdata[38:23], m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic add_pixel(input logic [15:0] value, input logic masked);
		pixel_q.push_back('{value, masked});
		n_queued++;
	endtask

	task automatic add_random(input int unsigned count, input int unsigned mask_pct);
		logic [15:0] v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				default: v = 16'($urandom);
			endcase
			add_pixel(v, $urandom_range(99) < mask_pct);
		end
	endtask

	task automatic drain();
		while (n_taken != n_queued || expected_q.size() != 0) @(posedge clk);
		// Row 0 pixels give no result, so let any work in flight settle.
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [11:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (index == REG_FRAME_WIDTH || index == REG_FRAME_HEIGHT) begin
			if (index == REG_FRAME_WIDTH) width_reg = data;
			else height_reg = data;
			col_pos = 0;
			row_pos = 0;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [11:0] w, input logic [11:0] h, input int unsigned si,
			input int unsigned rs);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		send_idle_pct = si;
		recv_stall_pct = rs;
	endtask

	initial begin
		for (int i = 0; i < 2048; i++) begin
			row_above2[i] = '0;
			row_above1[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = 12'd2048;
		height_reg = 12'd2048;
		n_queued = 0;
		n_taken = 0;
		errors = 0;
		pixel_taken = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Smallest frame: masked center with mixed neighbors at the value extremes.
		set_frame(12'd3, 12'd3, 0, 0);
		add_pixel(16'hFFFF, 1'b0); add_pixel(16'h0000, 1'b0); add_pixel(16'hFFFF, 1'b1);
		add_pixel(16'h0001, 1'b0); add_pixel(16'h1234, 1'b1); add_pixel(16'hFFFF, 1'b0);
		add_pixel(16'h0000, 1'b1); add_pixel(16'hFFFE, 1'b0); add_pixel(16'h8000, 1'b1);
		// Every pixel masked: the center has no good neighbor and passes through.
		for (int i = 0; i < 9; i++) add_pixel(16'(16'hA5A5 ^ i), 1'b1);
		// Corner-only good neighbors.
		add_pixel(16'd7, 1'b0); add_pixel(16'd9, 1'b1); add_pixel(16'd3, 1'b0);
		add_pixel(16'd1, 1'b1); add_pixel(16'd5, 1'b1); add_pixel(16'd2, 1'b1);
		add_pixel(16'hFFFF, 1'b0); add_pixel(16'd4, 1'b1); add_pixel(16'd0, 1'b0);
		drain();

		// Widest line, first pixels of the frame only.
		set_frame(12'd2048, 12'd3, 0, 0);
		add_random(12, 10);
		drain();

		// The sender holds off until every result is back, mid-frame.
		set_frame(12'd5, 12'd4, 54, 0);
		add_random(23, 30);
		drain();
		add_random(37, 30);
		drain();

		set_frame(12'd0, 12'd5, 0, 54);
		add_random(45, 40);
		drain();

		set_frame(12'd7, 12'd3, 31, 31);
		write_reg(8'd2, 12'($urandom));
		add_random(40, 90);
		drain();

		set_frame(12'd6, 12'd0, 54, 54);
		add_random(40, 25);
		drain();

		// Clamped and tallest settings, partial frames.
		set_frame(12'd4095, 12'd4095, 0, 0);
		add_random(20, 20);
		drain();
		set_frame(12'd3, 12'd4095, 31, 31);
		add_random(40, 30);
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: masked_pixel_neighbor_fill_top.f
+incdir+src
src/mpnf_pkg.sv
src/mpnf_queue.sv
src/mpnf_front.sv
src/mpnf_back.sv
src/masked_pixel_neighbor_fill_top.sv
src/mpnf_checker.sv
tb/masked_pixel_neighbor_fill_top_test.sv
